@@ sv/h2d_pkg.sv @@
package h2d_pkg;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Frame size after reset, before clamping to the build maximum
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Fixed field widths
  localparam int IN_PIXEL_W = 16;
  localparam int SIZE_W     = 13;
  localparam int COEF_W     = 18;
  localparam int BLOCK_W    = 11;

  // Stream word widths, padded to whole bytes
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 96;

endpackage

@@ sv/haar_2d_forward_level.sv @@
// Channel     | Dir | Signals                          | Word
// ------------+-----+----------------------------------+------------------------------------
// pixel in    | in  | s_axis_tvalid/tready/tdata       | pixel[15:0]
// block out   | out | m_axis_tvalid/tready/tdata/tlast | ll,hl,lh,hh,block_row,block_col;
//             |     |                                  | tlast = frame_end
// config      | in  | cfg_valid/ready/index/data       | index 0 frame_width, 1 frame_height
//
// Cycles: one pixel per clock unless the output stalls; a result passes the
//   middle stage and output register. The rate is set by the two line stores,
//   each with one write and one registered read port, touched once per pixel.
// Reset: clears counters, previous pixel, pipeline valids; the line stores are
//   not cleared and are only read at entries written earlier in the frame.
// Stalls: the output register and the middle stage each hold a word; input
//   stays ready while either has room, so a waiting result does not block.
module haar_2d_forward_level
  import h2d_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // pixel stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [15:0] pixel
  // block stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [17:0] ll_sum, [35:18] hl_sum,
                                                 // [53:36] lh_sum, [71:54] hh_sum,
                                                 // [82:72] block_row, [93:83] block_col,
                                                 // [95:94] zero
  output logic                   m_axis_tlast,   // frame_end
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data
);

  // Bits of the pixel actually used
  localparam int PW    = (PIXEL_BITS < IN_PIXEL_W) ? PIXEL_BITS : IN_PIXEL_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int PE    = 2 * (PW + 1);
  localparam int EW    = (PW + 3 > COEF_W) ? PW + 3 : COEF_W;
  localparam int XWC   = ((CW > SIZE_W) ? CW : SIZE_W) + 2;
  localparam int XRC   = ((RW > SIZE_W) ? RW : SIZE_W) + 2;
  localparam int W_LAST_RST =
    ((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST) - 1;
  localparam int H_LAST_RST =
    ((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST) - 1;

  // ---------------------------------------------------------------------------
  // Configuration: keep the last column / row position, already clamped
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  w_last;
  logic [RW-1:0]  h_last;
  logic [XWC-1:0] wv;
  logic [XRC-1:0] hv;
  logic [CW-1:0]  w_last_next;
  logic [RW-1:0]  h_last_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    wv = XWC'(cfg_data);
    hv = XRC'(cfg_data);
    if (wv < XWC'(2)) begin
      w_last_next = CW'(1);
    end else if (wv > XWC'(MAX_WIDTH)) begin
      w_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_next = CW'(wv - XWC'(1));
    end
    if (hv < XRC'(2)) begin
      h_last_next = RW'(1);
    end else if (hv > XRC'(MAX_HEIGHT)) begin
      h_last_next = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last_next = RW'(hv - XRC'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= CW'(W_LAST_RST);
      h_last <= RW'(H_LAST_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_last <= w_last_next;
        REG_FRAME_HEIGHT: h_last <= h_last_next;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enables: output register, then middle stage, then input
  // ---------------------------------------------------------------------------
  logic out_valid;
  logic s1_valid;
  logic out_en;
  logic s1_en;
  logic accept;

  assign out_en        = !out_valid || m_axis_tready;
  assign s1_en         = !s1_valid || out_en;
  assign s_axis_tready = s1_en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Input stage: form the pixel pair, address the line stores
  // ---------------------------------------------------------------------------
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [PW-1:0]      previous_pixel;
  logic [PW-1:0]      pix;
  logic               last_col;
  logic               last_row;
  logic               have_pair;
  logic [PW-1:0]      pa;
  logic [PW-1:0]      pb;
  logic [PW:0]        cur_sum;
  logic signed [PW:0] cur_diff;
  logic [CW-2:0]      half_col;
  logic [AW-1:0]      idx;
  logic               emit;
  logic               even_we;
  logic               odd_we;

  assign pix       = s_axis_tdata[PW-1:0];
  assign last_col  = col >= w_last;
  assign last_row  = row >= h_last;
  assign have_pair = col[0] || last_col;
  assign half_col  = col[CW-1:1];

  always_comb begin
    // odd column: previous is the left (plus) term; padded last column swaps
    if (col[0]) begin
      pa = previous_pixel;
      pb = pix;
    end else begin
      pa = pix;
      pb = previous_pixel;
    end
    cur_sum  = {1'b0, pa} + {1'b0, pb};
    cur_diff = $signed({1'b0, pa}) - $signed({1'b0, pb});
    if ({1'b0, half_col} >= CW'(DEPTH)) begin
      idx = AW'({1'b0, half_col} - CW'(DEPTH));
    end else begin
      idx = AW'(half_col);
    end
    emit    = have_pair && (row[0] || last_row);
    even_we = accept && have_pair && !row[0] && !last_row;
    odd_we  = accept && have_pair && row[0];
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col            <= '0;
      row            <= '0;
      previous_pixel <= '0;
    end else if (accept) begin
      previous_pixel <= pix;
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Line stores: entry = {diff, sum}. Odd rows read the even store, a padded
  // last even row reads the odd store.
  logic [PE-1:0] even_rdata;
  logic [PE-1:0] odd_rdata;

  h2d_ram #(
    .WIDTH (PE),
    .DEPTH (DEPTH)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (idx),
    .wdata ({cur_diff, cur_sum}),
    .re    (s1_en),
    .raddr (idx),
    .rdata (even_rdata)
  );

  h2d_ram #(
    .WIDTH (PE),
    .DEPTH (DEPTH)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (idx),
    .wdata ({cur_diff, cur_sum}),
    .re    (s1_en),
    .raddr (idx),
    .rdata (odd_rdata)
  );

  // ---------------------------------------------------------------------------
  // Middle stage: hold the current pair until the store data arrives
  // ---------------------------------------------------------------------------
  logic               s1_odd;
  logic [PW:0]        s1_sum;
  logic signed [PW:0] s1_diff;
  logic [BLOCK_W-1:0] s1_row;
  logic [BLOCK_W-1:0] s1_col;
  logic               s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_odd  <= row[0];
      s1_sum  <= cur_sum;
      s1_diff <= cur_diff;
      s1_row  <= BLOCK_W'(row >> 1);
      s1_col  <= BLOCK_W'(col >> 1);
      s1_last <= last_row && last_col;
    end
  end

  // Combine top and bottom pairs
  logic [PE-1:0]          rd_entry;
  logic [PW:0]            top_sum;
  logic [PW:0]            bot_sum;
  logic signed [PW:0]     top_diff;
  logic signed [PW:0]     bot_diff;
  logic signed [EW-1:0]   ts;
  logic signed [EW-1:0]   bs;
  logic signed [EW-1:0]   td;
  logic signed [EW-1:0]   bd;
  logic [EW-1:0]          ll_full;
  logic [EW-1:0]          hl_full;
  logic [EW-1:0]          lh_full;
  logic [EW-1:0]          hh_full;

  always_comb begin
    rd_entry = s1_odd ? even_rdata : odd_rdata;
    if (s1_odd) begin
      top_sum  = rd_entry[PW:0];
      top_diff = $signed(rd_entry[PE-1:PW+1]);
      bot_sum  = s1_sum;
      bot_diff = s1_diff;
    end else begin
      top_sum  = s1_sum;
      top_diff = s1_diff;
      bot_sum  = rd_entry[PW:0];
      bot_diff = $signed(rd_entry[PE-1:PW+1]);
    end
    ts = EW'(top_sum);
    bs = EW'(bot_sum);
    td = EW'(top_diff);
    bd = EW'(bot_diff);
    ll_full = ts + bs;
    hl_full = td + bd;
    lh_full = ts - bs;
    hh_full = td - bd;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0]  out_ll;
  logic [COEF_W-1:0]  out_hl;
  logic [COEF_W-1:0]  out_lh;
  logic [COEF_W-1:0]  out_hh;
  logic [BLOCK_W-1:0] out_row;
  logic [BLOCK_W-1:0] out_col;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_ll   <= ll_full[COEF_W-1:0];
      out_hl   <= hl_full[COEF_W-1:0];
      out_lh   <= lh_full[COEF_W-1:0];
      out_hh   <= hh_full[COEF_W-1:0];
      out_row  <= s1_row;
      out_col  <= s1_col;
      out_last <= s1_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_col, out_row, out_hh, out_lh, out_hl, out_ll};

endmodule

@@ sv/h2d_ram.sv @@
module h2d_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/h2d_checker.sv @@
module h2d_checker
  import h2d_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // A stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A stalled result keeps its word
  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Input is always open while no result waits
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // A new result follows a pixel taken in through the middle stage
  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input word");

endmodule

bind haar_2d_forward_level h2d_checker u_h2d_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
